### hdl/imhdk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhdk_pkg: shared types and constants
// Field widths, action and status codes, and the command and status bundles
// that join the controller and the datapath of the indexed min-heap unit.
// ----------------------------------------------------------------------------
package imhdk_pkg;

  localparam int NODE_W        = 10;
  localparam int KEY_PORT_W    = 64;
  localparam int ACT_W         = 2;
  localparam int STAT_W        = 2;
  localparam int CFG_W         = 11;
  localparam int ENTRY_RESET   = 1024;
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_KEY_BITS  = 64;

  localparam logic [ACT_W-1:0] ACT_MAKE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXTRACT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEC     = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY       = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_SMALLER = 2'd3;

  // heap slot read address
  typedef enum logic [2:0] {HA_ZERO, HA_LAST, HA_LEFT, HA_RIGHT, HA_UP} ha_sel_t;
  // key read address
  typedef enum logic {KA_HSQ, KA_NODE} ka_sel_t;
  // slot/node pair written by put_slot
  typedef enum logic [1:0] {PS_MOV, PS_BEST, PS_PAR, PS_MAKE} ps_sel_t;
  // key write source
  typedef enum logic {KW_MAKE, KW_DEC} kw_sel_t;
  // present write source
  typedef enum logic [1:0] {PW_CLR, PW_MAKE, PW_TOP} pw_sel_t;
  // current slot load
  typedef enum logic [2:0] {CUR_HOLD, CUR_ZERO, CUR_BEST, CUR_SON, CUR_UP} cur_sel_t;

  typedef struct packed {
    logic              acc;
    logic              cnt_clr;
    logic              cnt_inc;
    logic              size_make;
    logic              size_dec;
    logic              hs_re;
    ha_sel_t           hs_ra;
    logic              key_re;
    ka_sel_t           key_ra;
    logic              node_re;
    logic              ps_we;
    ps_sel_t           ps_sel;
    logic              key_we;
    kw_sel_t           kw_sel;
    logic              pr_we;
    pw_sel_t           pw_sel;
    logic              top_ld;
    logic              x2_ld;
    logic              x3_ld;
    logic              ln_ld;
    logic              lcmp;
    logic              rcmp;
    logic              dec_ld;
    logic              pn_ld;
    cur_sel_t          cur_sel;
    logic              st_ld;
    logic [STAT_W-1:0] st_code;
  } cmd_t;

  typedef struct packed {
    logic size_zero;
    logic size_one;
    logic l_in;
    logic r_in;
    logic best_mov;
    logic make_ok;
    logic node_ok;
    logic pres;
    logic key_less;
    logic cur_zero;
    logic mov_less;
    logic cnt_last;
    logic cnt_in;
  } sts_t;

endpackage

### hdl/indexed_min_heap_decrease_key_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_unit: indexed binary min-heap with keys
// Node ids keyed by a per-node distance; make_heap, extract_min and
// decrease_key, each answered by exactly one result transaction.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  input    | start & !busy        | in_action, in_node, in_new_key
//  result   | out_valid (1 cycle)  | out_min_node, out_min_key,
//           |                      | out_now_empty, out_status
//  config   | cfg_we               | cfg_wdata (entry_count)
//
//  make_heap walks over every id with one write per store and cycle.
//  extract_min sifts down and decrease_key bubbles up level by level; each
//  level is paced by the single read port of the slot and key stores (slot
//  read, then key read). Errors end before any store is written, and an
//  unknown action goes straight to its result.
//  Reset: a clearing pass over every id zeroes the present store;
//  busy stays high until it ends. Configuration writes are taken at any time.
//  The result is shown for one cycle and the receiver cannot stall it; one
//  transaction is worked on at a time, busy drops the cycle after out_valid.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_unit #(
  parameter int MAX_NODES = imhdk_pkg::DEF_MAX_NODES,
  parameter int KEY_BITS  = imhdk_pkg::DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input transaction
  input  logic                             start,
  output logic                             busy,
  input  logic [imhdk_pkg::ACT_W-1:0]      in_action,
  input  logic [imhdk_pkg::NODE_W-1:0]     in_node,
  input  logic [imhdk_pkg::KEY_PORT_W-1:0] in_new_key,
  // result transaction
  output logic                             out_valid,
  output logic [imhdk_pkg::NODE_W-1:0]     out_min_node,
  output logic [imhdk_pkg::KEY_PORT_W-1:0] out_min_key,
  output logic                             out_now_empty,
  output logic [imhdk_pkg::STAT_W-1:0]     out_status,
  // entry_count register
  input  logic                             cfg_we,
  input  logic [imhdk_pkg::CFG_W-1:0]      cfg_wdata
);
  import imhdk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: all ordering of memory reads and writes lives here
  imhdk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // stores, compare registers and result registers
  imhdk_dpath #(
    .MAX_NODES (MAX_NODES),
    .KEY_BITS  (KEY_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_node       (in_node),
    .in_new_key    (in_new_key),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_min_node  (out_min_node),
    .out_min_key   (out_min_key),
    .out_now_empty (out_now_empty),
    .out_status    (out_status)
  );

`ifndef SYNTHESIS
  // an accepted transaction keeps the unit busy until its result
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result strobe lasts exactly one cycle
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // no new transaction can be taken while a result is shown
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  // failed actions return zero node and key
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> ((out_min_node == '0) && (out_min_key == '0)))
    else $error("error result carries node or key");
`endif

endmodule

### hdl/imhdk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhdk_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module imhdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/imhdk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhdk_ctrl: sequencer of the min-heap unit
// Steps the datapath through clear, make, extract/sift-down and
// decrease/bubble-up sequences.
// ----------------------------------------------------------------------------
module imhdk_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [imhdk_pkg::ACT_W-1:0] in_action,
  input  imhdk_pkg::sts_t             sts,
  output imhdk_pkg::cmd_t             cmd,
  output logic                        busy,
  output logic                        out_valid
);
  import imhdk_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_MK0  = 5'd2;
  localparam logic [4:0] S_MKW  = 5'd3;
  localparam logic [4:0] S_X0   = 5'd4;
  localparam logic [4:0] S_X1   = 5'd5;
  localparam logic [4:0] S_X2   = 5'd6;
  localparam logic [4:0] S_X3   = 5'd7;
  localparam logic [4:0] S_SD0  = 5'd8;
  localparam logic [4:0] S_SD1  = 5'd9;
  localparam logic [4:0] S_SD2  = 5'd10;
  localparam logic [4:0] S_SD3  = 5'd11;
  localparam logic [4:0] S_SD4  = 5'd12;
  localparam logic [4:0] S_D0   = 5'd13;
  localparam logic [4:0] S_D1   = 5'd14;
  localparam logic [4:0] S_BU0  = 5'd15;
  localparam logic [4:0] S_BU1  = 5'd16;
  localparam logic [4:0] S_BU2  = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.acc = 1'b1;
          unique case (in_action)
            ACT_MAKE:    state_nxt = S_MK0;
            ACT_EXTRACT: state_nxt = S_X0;
            ACT_DEC:     state_nxt = S_D0;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        cmd.pr_we   = 1'b1;
        cmd.pw_sel  = PW_CLR;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_MK0: begin
        if (sts.make_ok) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_MKW;
        end else begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_ABSENT;
          state_nxt   = S_DONE;
        end
      end
      S_MKW: begin
        cmd.ps_we   = sts.cnt_in;
        cmd.ps_sel  = PS_MAKE;
        cmd.key_we  = sts.cnt_in;
        cmd.kw_sel  = KW_MAKE;
        cmd.pr_we   = 1'b1;
        cmd.pw_sel  = PW_MAKE;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.size_make = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_X0: begin
        if (sts.size_zero) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_EMPTY;
          state_nxt   = S_DONE;
        end else begin
          cmd.hs_re = 1'b1;
          cmd.hs_ra = HA_ZERO;
          state_nxt = S_X1;
        end
      end
      S_X1: begin
        cmd.top_ld = 1'b1;
        cmd.key_re = 1'b1;
        cmd.key_ra = KA_HSQ;
        cmd.hs_re  = 1'b1;
        cmd.hs_ra  = HA_LAST;
        state_nxt  = S_X2;
      end
      S_X2: begin
        cmd.x2_ld    = 1'b1;
        cmd.size_dec = 1'b1;
        cmd.pr_we    = 1'b1;
        cmd.pw_sel   = PW_TOP;
        cmd.key_re   = 1'b1;
        cmd.key_ra   = KA_HSQ;
        state_nxt    = sts.size_one ? S_DONE : S_X3;
      end
      S_X3: begin
        cmd.x3_ld   = 1'b1;
        cmd.cur_sel = CUR_ZERO;
        state_nxt   = S_SD0;
      end
      S_SD0: begin
        if (sts.l_in) begin
          cmd.hs_re = 1'b1;
          cmd.hs_ra = HA_LEFT;
          state_nxt = S_SD1;
        end else begin
          cmd.ps_we  = 1'b1;
          cmd.ps_sel = PS_MOV;
          state_nxt  = S_DONE;
        end
      end
      S_SD1: begin
        cmd.ln_ld  = 1'b1;
        cmd.key_re = 1'b1;
        cmd.key_ra = KA_HSQ;
        cmd.hs_re  = sts.r_in;
        cmd.hs_ra  = HA_RIGHT;
        state_nxt  = S_SD2;
      end
      S_SD2: begin
        cmd.lcmp   = 1'b1;
        cmd.key_re = sts.r_in;
        cmd.key_ra = KA_HSQ;
        state_nxt  = sts.r_in ? S_SD3 : S_SD4;
      end
      S_SD3: begin
        cmd.rcmp  = 1'b1;
        state_nxt = S_SD4;
      end
      S_SD4: begin
        cmd.ps_we = 1'b1;
        if (sts.best_mov) begin
          cmd.ps_sel = PS_MOV;
          state_nxt  = S_DONE;
        end else begin
          cmd.ps_sel  = PS_BEST;
          cmd.cur_sel = CUR_BEST;
          state_nxt   = S_SD0;
        end
      end
      S_D0: begin
        if (sts.node_ok) begin
          cmd.node_re = 1'b1;
          cmd.key_re  = 1'b1;
          cmd.key_ra  = KA_NODE;
          state_nxt   = S_D1;
        end else begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_ABSENT;
          state_nxt   = S_DONE;
        end
      end
      S_D1: begin
        if (!sts.pres) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_ABSENT;
          state_nxt   = S_DONE;
        end else if (!sts.key_less) begin
          cmd.st_ld   = 1'b1;
          cmd.st_code = ST_NOT_SMALLER;
          state_nxt   = S_DONE;
        end else begin
          cmd.key_we  = 1'b1;
          cmd.kw_sel  = KW_DEC;
          cmd.dec_ld  = 1'b1;
          cmd.cur_sel = CUR_SON;
          state_nxt   = S_BU0;
        end
      end
      S_BU0: begin
        if (sts.cur_zero) begin
          cmd.ps_we  = 1'b1;
          cmd.ps_sel = PS_MOV;
          state_nxt  = S_DONE;
        end else begin
          cmd.hs_re = 1'b1;
          cmd.hs_ra = HA_UP;
          state_nxt = S_BU1;
        end
      end
      S_BU1: begin
        cmd.pn_ld  = 1'b1;
        cmd.key_re = 1'b1;
        cmd.key_ra = KA_HSQ;
        state_nxt  = S_BU2;
      end
      S_BU2: begin
        cmd.ps_we = 1'b1;
        if (sts.mov_less) begin
          cmd.ps_sel  = PS_PAR;
          cmd.cur_sel = CUR_UP;
          state_nxt   = S_BU0;
        end else begin
          cmd.ps_sel = PS_MOV;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

### hdl/imhdk_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imhdk_dpath: storage and datapath of the min-heap unit
// Slot, position, key and present stores, walk counter, heap size, the
// moving entry and the child/parent compare registers.
// ----------------------------------------------------------------------------
module imhdk_dpath #(
  parameter int MAX_NODES = imhdk_pkg::DEF_MAX_NODES,
  parameter int KEY_BITS  = imhdk_pkg::DEF_KEY_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  imhdk_pkg::cmd_t                  cmd,
  output imhdk_pkg::sts_t                  sts,
  input  logic [imhdk_pkg::NODE_W-1:0]     in_node,
  input  logic [imhdk_pkg::KEY_PORT_W-1:0] in_new_key,
  input  logic                             cfg_we,
  input  logic [imhdk_pkg::CFG_W-1:0]      cfg_wdata,
  output logic [imhdk_pkg::NODE_W-1:0]     out_min_node,
  output logic [imhdk_pkg::KEY_PORT_W-1:0] out_min_key,
  output logic                             out_now_empty,
  output logic [imhdk_pkg::STAT_W-1:0]     out_status
);
  import imhdk_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int SIZE_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W  = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;

  // control state
  logic [CFG_W-1:0]    ent_cnt_r;
  logic [SIZE_W-1:0]   size_r;
  logic [IDX_W-1:0]    cnt_r;

  // payload
  logic [NODE_W-1:0]   node_r;
  logic [KEY_BITS-1:0] nkey_r;
  logic [IDX_W-1:0]    cur_r;
  logic [IDX_W-1:0]    mov_node_r;
  logic [KEY_BITS-1:0] mov_key_r;
  logic [IDX_W-1:0]    topn_r;
  logic [IDX_W-1:0]    ln_r;
  logic [IDX_W-1:0]    rn_r;
  logic [IDX_W-1:0]    pn_r;
  logic [IDX_W-1:0]    best_node_r;
  logic [IDX_W-1:0]    best_slot_r;
  logic [KEY_BITS-1:0] best_key_r;
  logic                best_mov_r;
  logic [IDX_W-1:0]    res_node_r;
  logic [KEY_BITS-1:0] res_key_r;
  logic [STAT_W-1:0]   status_r;

  // memory ports
  logic [IDX_W-1:0]    hs_q, son_q;
  logic [KEY_BITS-1:0] key_q;
  logic                pr_q;
  logic [IDX_W-1:0]    hs_ra, key_ra;
  logic [IDX_W-1:0]    ps_slot, ps_id;
  logic [IDX_W-1:0]    key_wa;
  logic [KEY_BITS-1:0] key_wd;
  logic [IDX_W-1:0]    pr_wa;
  logic                pr_wd;

  // derived values
  logic [IDX_W-1:0]    node_ix;
  logic [IDX_W:0]      lft;
  logic [IDX_W+1:0]    rgt;
  logic [IDX_W-1:0]    up_slot;
  logic [CMP_W-1:0]    ent_ext;
  logic [SIZE_W-1:0]   n_sat;
  logic [IDX_W-1:0]    mk_slot;
  logic [KEY_BITS-1:0] mk_key;
  logic                cnt_in;

  assign node_ix = IDX_W'(node_r);
  assign lft     = {cur_r, 1'b1};
  assign rgt     = (IDX_W+2)'(lft) + (IDX_W+2)'(1);
  assign up_slot = (cur_r - IDX_W'(1)) >> 1;
  assign ent_ext = CMP_W'(ent_cnt_r);

  always_comb begin
    if (ent_ext == '0) begin
      n_sat = SIZE_W'(1);
    end else if (ent_ext > CMP_W'(MAX_NODES)) begin
      n_sat = SIZE_W'(MAX_NODES);
    end else begin
      n_sat = SIZE_W'(ent_ext);
    end
  end

  assign cnt_in = (SIZE_W'(cnt_r) < n_sat);

  // start node goes to slot 0; lower ids shift up by one slot
  always_comb begin
    if (cnt_r == node_ix) begin
      mk_slot = '0;
    end else if (cnt_r < node_ix) begin
      mk_slot = cnt_r + IDX_W'(1);
    end else begin
      mk_slot = cnt_r;
    end
  end
  assign mk_key = (cnt_r == node_ix) ? '0 : '1;

  always_comb begin
    case (cmd.hs_ra)
      HA_ZERO:  hs_ra = '0;
      HA_LAST:  hs_ra = IDX_W'(size_r - SIZE_W'(1));
      HA_LEFT:  hs_ra = IDX_W'(lft);
      HA_RIGHT: hs_ra = IDX_W'(rgt);
      HA_UP:    hs_ra = up_slot;
      default:  hs_ra = '0;
    endcase
  end

  assign key_ra = (cmd.key_ra == KA_NODE) ? node_ix : hs_q;

  always_comb begin
    case (cmd.ps_sel)
      PS_MOV: begin
        ps_slot = cur_r;
        ps_id   = mov_node_r;
      end
      PS_BEST: begin
        ps_slot = cur_r;
        ps_id   = best_node_r;
      end
      PS_PAR: begin
        ps_slot = cur_r;
        ps_id   = pn_r;
      end
      default: begin
        ps_slot = mk_slot;
        ps_id   = cnt_r;
      end
    endcase
  end

  assign key_wa = (cmd.kw_sel == KW_DEC) ? node_ix : cnt_r;
  assign key_wd = (cmd.kw_sel == KW_DEC) ? nkey_r : mk_key;

  always_comb begin
    case (cmd.pw_sel)
      PW_MAKE: begin
        pr_wa = cnt_r;
        pr_wd = cnt_in;
      end
      PW_TOP: begin
        pr_wa = topn_r;
        pr_wd = 1'b0;
      end
      default: begin
        pr_wa = cnt_r;
        pr_wd = 1'b0;
      end
    endcase
  end

  imhdk_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_slots (
    .clk(clk), .we(cmd.ps_we), .waddr(ps_slot), .wdata(ps_id),
    .re(cmd.hs_re), .raddr(hs_ra), .rdata(hs_q)
  );

  imhdk_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_pos (
    .clk(clk), .we(cmd.ps_we), .waddr(ps_id), .wdata(ps_slot),
    .re(cmd.node_re), .raddr(node_ix), .rdata(son_q)
  );

  imhdk_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_NODES)) u_keys (
    .clk(clk), .we(cmd.key_we), .waddr(key_wa), .wdata(key_wd),
    .re(cmd.key_re), .raddr(key_ra), .rdata(key_q)
  );

  imhdk_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_pres (
    .clk(clk), .we(cmd.pr_we), .waddr(pr_wa), .wdata(pr_wd),
    .re(cmd.node_re), .raddr(node_ix), .rdata(pr_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_cnt_r <= CFG_W'(ENTRY_RESET);
      size_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        ent_cnt_r <= cfg_wdata;
      end
      if (cmd.size_make) begin
        size_r <= n_sat;
      end else if (cmd.size_dec) begin
        size_r <= size_r - SIZE_W'(1);
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      node_r     <= in_node;
      nkey_r     <= KEY_BITS'(in_new_key);
      res_node_r <= '0;
      res_key_r  <= '0;
      status_r   <= ST_OK;
    end
    if (cmd.st_ld) begin
      status_r <= cmd.st_code;
    end
    if (cmd.top_ld) begin
      topn_r <= hs_q;
    end
    if (cmd.x2_ld) begin
      res_node_r <= topn_r;
      res_key_r  <= key_q;
      mov_node_r <= hs_q;
    end
    if (cmd.x3_ld) begin
      mov_key_r <= key_q;
    end
    if (cmd.dec_ld) begin
      mov_node_r <= node_ix;
      mov_key_r  <= nkey_r;
    end
    if (cmd.ln_ld) begin
      ln_r <= hs_q;
    end
    if (cmd.lcmp) begin
      rn_r <= hs_q;
      if (key_q < mov_key_r) begin
        best_key_r  <= key_q;
        best_node_r <= ln_r;
        best_slot_r <= IDX_W'(lft);
        best_mov_r  <= 1'b0;
      end else begin
        best_key_r <= mov_key_r;
        best_mov_r <= 1'b1;
      end
    end
    if (cmd.rcmp && (key_q < best_key_r)) begin
      best_key_r  <= key_q;
      best_node_r <= rn_r;
      best_slot_r <= IDX_W'(rgt);
      best_mov_r  <= 1'b0;
    end
    if (cmd.pn_ld) begin
      pn_r <= hs_q;
    end
    case (cmd.cur_sel)
      CUR_ZERO: cur_r <= '0;
      CUR_BEST: cur_r <= best_slot_r;
      CUR_SON:  cur_r <= son_q;
      CUR_UP:   cur_r <= up_slot;
      default:  cur_r <= cur_r;
    endcase
  end

  assign sts.size_zero = (size_r == '0);
  assign sts.size_one  = (size_r == SIZE_W'(1));
  assign sts.l_in      = ((IDX_W+2)'(lft) < (IDX_W+2)'(size_r));
  assign sts.r_in      = (rgt < (IDX_W+2)'(size_r));
  assign sts.best_mov  = best_mov_r;
  assign sts.make_ok   = (32'(node_r) < 32'(n_sat));
  assign sts.node_ok   = (32'(node_r) < 32'(MAX_NODES));
  assign sts.pres      = pr_q;
  assign sts.key_less  = (nkey_r < key_q);
  assign sts.cur_zero  = (cur_r == '0);
  assign sts.mov_less  = (mov_key_r < key_q);
  assign sts.cnt_last  = (cnt_r == IDX_W'(MAX_NODES - 1));
  assign sts.cnt_in    = cnt_in;

  assign out_min_node  = NODE_W'(res_node_r);
  assign out_min_key   = KEY_PORT_W'(res_key_r);
  assign out_now_empty = (size_r == '0);
  assign out_status    = status_r;

endmodule

### bench/indexed_min_heap_decrease_key_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_unit_test: self-checking bench for the heap
// A directed table walks the error codes, the extremes of every field and
// entry_count saturation. Random Dijkstra-like phases follow: a make_heap,
// then a mix of extracts and decrease_keys with some noise. Every result is
// checked field by field against a local heap predictor or a typed want.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_unit_test;
  import imhdk_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;  // unknown action, no effect
  localparam int NODES = DEF_MAX_NODES;
  localparam int ITEM_TARGET = 1450;

  typedef struct packed {
    logic [NODE_W-1:0]     node;
    logic [KEY_PORT_W-1:0] key;
    logic                  empty;
    logic [STAT_W-1:0]     status;
  } heap_result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_W-1:0]      cfg_val;
    logic [ACT_W-1:0]      act;
    logic [NODE_W-1:0]     node;
    logic [KEY_PORT_W-1:0] key;
    logic                  typed;  // compare against want instead of predictor
    heap_result_t          want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ACT_W-1:0]      in_action = '0;
  logic [NODE_W-1:0]     in_node = '0;
  logic [KEY_PORT_W-1:0] in_new_key = '0;
  logic                  out_valid;
  logic [NODE_W-1:0]     out_min_node;
  logic [KEY_PORT_W-1:0] out_min_key;
  logic                  out_now_empty;
  logic [STAT_W-1:0]     out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  indexed_min_heap_decrease_key_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_node      (in_node),
    .in_new_key   (in_new_key),
    .out_valid    (out_valid),
    .out_min_node (out_min_node),
    .out_min_key  (out_min_key),
    .out_now_empty(out_now_empty),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---- heap predictor state ----
  logic [NODE_W-1:0]     slot_node [NODES];
  logic [NODE_W-1:0]     node_slot [NODES];
  logic [KEY_PORT_W-1:0] node_key  [NODES];
  bit                    in_heap   [NODES];
  int                    heap_cnt = 0;
  int                    entry_cfg = ENTRY_RESET;

  heap_result_t pending_results[$];
  bit           failed = 1'b0;
  bit           burst = 1'b0;  // no gaps between transactions while set
  int           item_cnt = 0;

  function automatic void place(int slot, logic [NODE_W-1:0] id);
    slot_node[slot] = id;
    node_slot[id]   = slot[NODE_W-1:0];
  endfunction

  function automatic logic [KEY_PORT_W-1:0] slot_key(int slot);
    return node_key[slot_node[slot]];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [NODE_W-1:0] t;
    t = slot_node[a];
    place(a, slot_node[b]);
    place(b, t);
  endfunction

  // Applies one transaction to the predicted heap and returns its result.
  function automatic heap_result_t heap_predict(logic [ACT_W-1:0] act,
                                                logic [NODE_W-1:0] nd,
                                                logic [KEY_PORT_W-1:0] k);
    heap_result_t r;
    int n, i, s, best, up;
    r = '0;
    r.status = ST_OK;
    case (act)
      ACT_MAKE: begin
        n = entry_cfg;
        if (n < 1) n = 1;
        if (n > NODES) n = NODES;
        if (nd >= n) begin
          r.status = ST_ABSENT;
        end else begin
          for (i = 0; i < NODES; i++) begin
            in_heap[i] = (i < n);
            if (i < n) node_key[i] = '1;
          end
          node_key[nd] = '0;
          place(0, nd);
          for (i = 1; i <= nd; i++) place(i, NODE_W'(i - 1));
          for (; i < n; i++) place(i, NODE_W'(i));
          heap_cnt = n;
        end
      end
      ACT_EXTRACT: begin
        if (heap_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.node = slot_node[0];
          r.key  = node_key[slot_node[0]];
          in_heap[slot_node[0]] = 1'b0;
          heap_cnt--;
          if (heap_cnt > 0) begin
            place(0, slot_node[heap_cnt]);
            // sift down; strict compare keeps the parent on ties
            s = 0;
            forever begin
              best = s;
              if (2*s+1 < heap_cnt && slot_key(2*s+1) < slot_key(best)) best = 2*s+1;
              if (2*s+2 < heap_cnt && slot_key(2*s+2) < slot_key(best)) best = 2*s+2;
              if (best == s) break;
              swap_slots(s, best);
              s = best;
            end
          end
        end
      end
      ACT_DEC: begin
        if (!in_heap[nd]) begin
          r.status = ST_ABSENT;
        end else if (!(k < node_key[nd])) begin
          r.status = ST_NOT_SMALLER;
        end else begin
          node_key[nd] = k;
          s = int'(node_slot[nd]);
          while (s > 0) begin
            up = (s - 1) / 2;
            if (!(slot_key(s) < slot_key(up))) break;
            swap_slots(s, up);
            s = up;
          end
        end
      end
      default: ;
    endcase
    r.empty = (heap_cnt == 0);
    return r;
  endfunction

  // Drives one transaction, waits for it to be taken, records the expectation.
  task automatic issue(logic [ACT_W-1:0] act, logic [NODE_W-1:0] nd,
                       logic [KEY_PORT_W-1:0] k, bit typed, heap_result_t want);
    heap_result_t got;
    int gap;
    @(negedge clk);
    in_action  = act;
    in_node    = nd;
    in_new_key = k;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    got = heap_predict(act, nd, k);
    pending_results.push_back(typed ? want : got);
    item_cnt++;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Every transaction answers, so an empty queue means the unit is idle.
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [CFG_W-1:0] v);
    @(negedge clk);
    start = 1'b0;
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = CFG_W'($urandom);
    entry_cfg = v;
  endtask

  // ---- result checker ----
  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        failed = 1'b1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_min_node !== exp_r.node) begin
          $error("min_node: expected %0d, got %0d", exp_r.node, out_min_node);
          failed = 1'b1;
        end
        if (out_min_key !== exp_r.key) begin
          $error("min_key: expected %h, got %h", exp_r.key, out_min_key);
          failed = 1'b1;
        end
        if (out_now_empty !== exp_r.empty) begin
          $error("now_empty: expected %0d, got %0d", exp_r.empty, out_now_empty);
          failed = 1'b1;
        end
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  // ---- directed table ----
  localparam logic [KEY_PORT_W-1:0] ONES = '1;
  localparam logic [KEY_PORT_W-1:0] MSB  = 64'h8000_0000_0000_0000;

  stim_row_t directed [] = '{
    // empty heap after reset
    '{0, 0, ACT_EXTRACT, 0, 0, 1, '{0, 0, 1, ST_EMPTY}},
    '{0, 0, ACT_DEC, 0, 5, 1, '{0, 0, 1, ST_ABSENT}},
    '{0, 0, ACT_NOP, 10'h3ff, ONES, 1, '{0, 0, 1, ST_OK}},
    // full-size heap rooted at the highest id
    '{0, 0, ACT_MAKE, 10'h3ff, ONES, 1, '{0, 0, 0, ST_OK}},
    '{0, 0, ACT_EXTRACT, 0, 0, 1, '{10'h3ff, 0, 0, ST_OK}},
    '{0, 0, ACT_DEC, 10'h3ff, 0, 1, '{0, 0, 0, ST_ABSENT}},
    '{0, 0, ACT_DEC, 5, ONES, 1, '{0, 0, 0, ST_NOT_SMALLER}},
    '{0, 0, ACT_DEC, 5, 0, 1, '{0, 0, 0, ST_OK}},
    '{0, 0, ACT_EXTRACT, 0, 0, 1, '{5, 0, 0, ST_OK}},
    // equal keys: ties resolved by heap position
    '{0, 0, ACT_DEC, 700, MSB, 0, '0},
    '{0, 0, ACT_DEC, 9, MSB, 0, '0},
    '{0, 0, ACT_DEC, 9, MSB, 0, '0},
    '{0, 0, ACT_EXTRACT, 0, 0, 0, '0},
    '{0, 0, ACT_EXTRACT, 0, 0, 0, '0},
    '{0, 0, ACT_EXTRACT, 0, 0, 0, '0},
    // entry_count zero saturates to one
    '{1, 11'd0, 0, 0, 0, 0, '0},
    '{0, 0, ACT_MAKE, 1, 0, 1, '{0, 0, 0, ST_ABSENT}},
    '{0, 0, ACT_MAKE, 0, 0, 1, '{0, 0, 0, ST_OK}},
    '{0, 0, ACT_EXTRACT, 0, 0, 1, '{0, 0, 1, ST_OK}},
    '{0, 0, ACT_EXTRACT, 0, 0, 1, '{0, 0, 1, ST_EMPTY}},
    // entry_count above range saturates to the full size
    '{1, 11'h7ff, 0, 0, 0, 0, '0},
    '{0, 0, ACT_MAKE, 10'h3ff, 0, 1, '{0, 0, 0, ST_OK}},
    '{1, 11'd3, 0, 0, 0, 0, '0},
    '{0, 0, ACT_MAKE, 2, 0, 1, '{0, 0, 0, ST_OK}},
    '{0, 0, ACT_DEC, 0, 1, 0, '0},
    '{0, 0, ACT_EXTRACT, 0, 0, 0, '0},
    '{0, 0, ACT_EXTRACT, 0, 0, 0, '0},
    '{0, 0, ACT_EXTRACT, 0, 0, 1, '{1, ONES, 1, ST_OK}}
  };

  // Counts used by the random phases; extremes included, small ones dominate.
  int count_pool [] = '{1, 2, 3, 4, 5, 7, 8, 13, 16, 31, 33, 64, 0, 1024, 2047, 1500};

  initial begin
    logic [KEY_PORT_W-1:0] k, r64;
    logic [NODE_W-1:0]     nd;
    int                    n, ops, sel, pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg)
        write_entry_count(directed[i].cfg_val);
      else
        issue(directed[i].act, directed[i].node, directed[i].key,
              directed[i].typed, directed[i].want);
    end

    while (item_cnt < ITEM_TARGET) begin
      // large counts are slow to drain, so they come up rarely
      pick = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
      write_entry_count(count_pool[pick][CFG_W-1:0]);
      burst = ($urandom_range(0, 3) == 0);
      n = entry_cfg < 1 ? 1 : (entry_cfg > NODES ? NODES : entry_cfg);

      // occasionally a start out of range first
      if (n < NODES && $urandom_range(0, 5) == 0)
        issue(ACT_MAKE, NODE_W'($urandom_range(n, NODES - 1)), {$urandom, $urandom},
              0, '0);
      issue(ACT_MAKE, NODE_W'($urandom_range(0, n - 1)), {$urandom, $urandom}, 0, '0);

      ops = (n > 64) ? $urandom_range(40, 150) : 3 * n + $urandom_range(2, 8);
      repeat (ops) begin
        sel = $urandom_range(0, 99);
        r64 = {$urandom, $urandom};
        if (sel < 45) begin
          issue(ACT_EXTRACT, NODE_W'($urandom), r64, 0, '0);
        end else if (sel < 88) begin
          nd = NODE_W'($urandom_range(0, n - 1));
          case ($urandom_range(0, 9))
            0: k = node_key[nd];
            1: k = r64;
            2: k = node_key[nd] - 1;
            default: k = (node_key[nd] == 0) ? r64 : r64 % node_key[nd];
          endcase
          issue(ACT_DEC, nd, k, 0, '0);
        end else if (sel < 94) begin
          issue(ACT_DEC, NODE_W'($urandom), r64, 0, '0);
        end else begin
          issue(ACT_NOP, NODE_W'($urandom), r64, 0, '0);
        end
      end
    end

    @(negedge clk);
    start = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hdl/imhdk_pkg.sv
hdl/imhdk_ram.sv
hdl/imhdk_ctrl.sv
hdl/imhdk_dpath.sv
hdl/indexed_min_heap_decrease_key_unit.sv
bench/indexed_min_heap_decrease_key_unit_test.sv
